// ----- hdl/lprf_pkg.sv -----
// Package with shared constants, codes and types of the length-prefixed record FIFO.
package lprf_pkg;

  localparam int unsigned DEPTH_DEF        = 16;
  localparam int unsigned RECORD_BYTES_DEF = 64;
  localparam int unsigned LEN_W            = 7;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned STATUS_W         = 2;
  localparam logic [LEN_W-1:0] MAX_COUNT   = 7'd64;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LEN    = 3'b010,
    ST_STREAM = 3'b100
  } state_t;

endpackage

// ----- hdl/lprf_byte_mem.sv -----
// Synchronous byte store holding the data bytes of every record slot.
module lprf_byte_mem
  import lprf_pkg::*;
#(
  parameter int unsigned WORDS  = DEPTH_DEF * RECORD_BYTES_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH_DEF * RECORD_BYTES_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [WORDS];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/lprf_len_mem.sv -----
// Synchronous store of the committed length of every record slot.
module lprf_len_mem
  import lprf_pkg::*;
#(
  parameter int unsigned DEPTH  = DEPTH_DEF,
  parameter int unsigned SLOT_W = $clog2(DEPTH_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [LEN_W-1:0]  wr_data,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [LEN_W-1:0]  rd_data
);

  logic [LEN_W-1:0] mem [DEPTH];
  logic [LEN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/length_prefixed_record_fifo_unit.sv -----
// Top level of the length-prefixed record FIFO: ring control, read sequencer and outputs.
//
//   Channel  Handshake               Payload
//   in_      start / busy            operation, data_byte, byte_valid, last, read_count
//   out_     out_strobe (one cycle)  status, byte, valid, last, stored_length
//   cfg_     cfg_valid / cfg_ready   cfg_data (record limit)
//
// A write request never raises busy; a final write byte gives its result, registered, in
// the cycle after the request. A read request holds busy for a length lookup in ST_LEN and
// then, if any bytes are due, streams them from ST_STREAM, paced by the registered reads of
// the length and byte memories. Empty reads answer in the cycle after the request.
// Reset clears the ring pointers, the fill count and the open record; memories are
// not cleared. The receiver cannot stall, so every result shows for exactly one cycle.
module length_prefixed_record_fifo_unit
  import lprf_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_byte_valid,
  input  logic              in_last,
  input  logic [LEN_W-1:0]  in_read_count,
  output logic              out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_valid,
  output logic              out_last,
  output logic [LEN_W-1:0]  out_stored_length,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORDS  = DEPTH * RECORD_BYTES;
  localparam int unsigned ADDR_W = $clog2(WORDS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(DEPTH);
  localparam logic [LEN_W-1:0]  REC_MAX   = LEN_W'(RECORD_BYTES);
  localparam logic [ADDR_W-1:0] REC_STEP  = ADDR_W'(RECORD_BYTES);

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [LEN_W-1:0]  open_bytes_r, open_bytes_nxt;
  logic              dropping_r, dropping_nxt;
  logic [LEN_W-1:0]  limit_r;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  total_r, total_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;

  logic              strobe_r, strobe_nxt;
  status_t           status_r, status_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              valid_r, valid_nxt;
  logic              last_r, last_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;

  logic              accept;
  logic              full;
  logic [LEN_W-1:0]  limit_eff;
  logic              drop_now;
  logic              byte_wr_en;
  logic [ADDR_W-1:0] byte_wr_addr;
  logic [ADDR_W-1:0] byte_rd_addr;
  logic [BYTE_W-1:0] byte_rd_data;
  logic [LEN_W-1:0]  rd_offset;
  logic              len_wr_en;
  logic [LEN_W-1:0]  len_rd_data;
  logic [LEN_W-1:0]  len_clamped;
  logic [LEN_W-1:0]  n_bytes;
  logic              final_byte;
  logic [SLOT_W-1:0] read_slot_inc;
  logic [SLOT_W-1:0] write_slot_inc;
  logic [LEN_W-1:0]  commit_len;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (occ_r >= OCC_FULL);
  assign limit_eff = (limit_r > REC_MAX) ? REC_MAX : limit_r;
  assign drop_now  = dropping_r || (in_byte_valid && full);

  assign read_slot_inc  = (read_slot_r == LAST_SLOT) ? '0 : SLOT_W'(read_slot_r + 1'b1);
  assign write_slot_inc = (write_slot_r == LAST_SLOT) ? '0 : SLOT_W'(write_slot_r + 1'b1);

  assign byte_wr_en   = accept && (in_operation == OP_WRITE) && in_byte_valid && !drop_now
                        && (open_bytes_r < limit_eff);
  assign byte_wr_addr = ADDR_W'(ADDR_W'(write_slot_r) * REC_STEP + ADDR_W'(open_bytes_r));
  assign rd_offset    = (state_r == ST_LEN) ? '0 : LEN_W'(idx_r + 1'b1);
  assign byte_rd_addr = ADDR_W'(ADDR_W'(read_slot_r) * REC_STEP + ADDR_W'(rd_offset));

  assign commit_len  = byte_wr_en ? LEN_W'(open_bytes_r + 1'b1) : open_bytes_r;
  assign len_wr_en   = accept && (in_operation == OP_WRITE) && in_last && !drop_now && !full;
  assign len_clamped = (len_rd_data > REC_MAX) ? REC_MAX : len_rd_data;
  assign n_bytes     = (count_r < len_clamped) ? count_r : len_clamped;
  assign final_byte  = (LEN_W'(idx_r + 1'b1) == total_r);

  lprf_byte_mem #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_byte_mem (
    .clk     (clk),
    .wr_en   (byte_wr_en),
    .wr_addr (byte_wr_addr),
    .wr_data (in_data_byte),
    .rd_addr (byte_rd_addr),
    .rd_data (byte_rd_data)
  );

  lprf_len_mem #(
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W)
  ) u_len_mem (
    .clk     (clk),
    .wr_en   (len_wr_en),
    .wr_addr (write_slot_r),
    .wr_data (commit_len),
    .rd_addr (read_slot_r),
    .rd_data (len_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    read_slot_nxt  = read_slot_r;
    write_slot_nxt = write_slot_r;
    occ_nxt        = occ_r;
    open_bytes_nxt = open_bytes_r;
    dropping_nxt   = dropping_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    strobe_nxt     = 1'b0;
    status_nxt     = STATUS_OK;
    byte_nxt       = '0;
    valid_nxt      = 1'b0;
    last_nxt       = 1'b1;
    length_nxt     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_WRITE) begin
            dropping_nxt   = drop_now;
            open_bytes_nxt = commit_len;
            if (in_last) begin
              strobe_nxt     = 1'b1;
              open_bytes_nxt = '0;
              dropping_nxt   = 1'b0;
              if (drop_now || full) begin
                status_nxt = STATUS_FULL;
              end else begin
                length_nxt     = commit_len;
                write_slot_nxt = write_slot_inc;
                occ_nxt        = OCC_W'(occ_r + 1'b1);
              end
            end
          end else if (occ_r == '0) begin
            strobe_nxt = 1'b1;
            status_nxt = STATUS_EMPTY;
          end else begin
            count_nxt = (in_read_count > MAX_COUNT) ? MAX_COUNT : in_read_count;
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        idx_nxt   = '0;
        total_nxt = n_bytes;
        if (n_bytes == '0) begin
          strobe_nxt    = 1'b1;
          read_slot_nxt = read_slot_inc;
          occ_nxt       = OCC_W'(occ_r - 1'b1);
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_STREAM;
        end
      end
      ST_STREAM: begin
        strobe_nxt = 1'b1;
        byte_nxt   = byte_rd_data;
        valid_nxt  = 1'b1;
        last_nxt   = final_byte;
        length_nxt = total_r;
        idx_nxt    = LEN_W'(idx_r + 1'b1);
        if (final_byte) begin
          read_slot_nxt = read_slot_inc;
          occ_nxt       = OCC_W'(occ_r - 1'b1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_slot_r  <= '0;
      write_slot_r <= '0;
      occ_r        <= '0;
      open_bytes_r <= '0;
      dropping_r   <= 1'b0;
      limit_r      <= LIMIT_RESET;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_slot_r  <= read_slot_nxt;
      write_slot_r <= write_slot_nxt;
      occ_r        <= occ_nxt;
      open_bytes_r <= open_bytes_nxt;
      dropping_r   <= dropping_nxt;
      strobe_r     <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r  <= count_nxt;
    total_r  <= total_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    byte_r   <= byte_nxt;
    valid_r  <= valid_nxt;
    last_r   <= last_nxt;
    length_r <= length_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_byte          = byte_r;
  assign out_valid         = valid_r;
  assign out_last          = last_r;
  assign out_stored_length = length_r;

endmodule

// ----- dv/lprf_record_checker.sv -----
// Checker for the record FIFO: predicts the results of each request and compares them.
module lprf_record_checker
  import lprf_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_operation,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                in_byte_valid,
  input  logic                in_last,
  input  logic [LEN_W-1:0]    in_read_count,
  input  logic                out_strobe,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [BYTE_W-1:0]   out_byte,
  input  logic                out_valid,
  input  logic                out_last,
  input  logic [LEN_W-1:0]    out_stored_length,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [LEN_W-1:0]    cfg_data,
  output int                  mismatches,
  output int                  pending_results
);

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              last;
    logic [LEN_W-1:0]  length;
  } fifo_result_t;

  logic [BYTE_W-1:0] byte_mem [DEPTH*RECORD_BYTES];
  logic [LEN_W-1:0]  length_mem [DEPTH];
  int unsigned       head_slot;
  int unsigned       tail_slot;
  int unsigned       fill;
  int unsigned       open_len;
  logic              dropping;
  logic [LEN_W-1:0]  record_limit;
  fifo_result_t      awaited_results [$];

  initial begin
    mismatches      = 0;
    pending_results = 0;
  end

  function automatic int unsigned ring_next(int unsigned slot);
    return (slot + 1 >= DEPTH) ? 0 : slot + 1;
  endfunction

  task automatic await_result(status_t st, logic [BYTE_W-1:0] data, logic valid, logic last,
                              logic [LEN_W-1:0] length);
    fifo_result_t r;
    r.status = st;
    r.data   = data;
    r.valid  = valid;
    r.last   = last;
    r.length = length;
    awaited_results.push_back(r);
  endtask

  task automatic predict_fifo_results();
    int unsigned lim;
    int unsigned count;
    int unsigned len;
    int unsigned n;
    if (in_operation == OP_WRITE) begin
      lim = (record_limit > RECORD_BYTES) ? RECORD_BYTES : record_limit;
      if (in_byte_valid) begin
        if (fill >= DEPTH) dropping = 1'b1;
        if (!dropping && open_len < lim) begin
          byte_mem[tail_slot*RECORD_BYTES + open_len] = in_data_byte;
          open_len++;
        end
      end
      if (in_last) begin
        if (dropping || fill >= DEPTH) begin
          await_result(STATUS_FULL, '0, 1'b0, 1'b1, '0);
        end else begin
          length_mem[tail_slot] = open_len[LEN_W-1:0];
          await_result(STATUS_OK, '0, 1'b0, 1'b1, open_len[LEN_W-1:0]);
          tail_slot = ring_next(tail_slot);
          fill++;
        end
        open_len = 0;
        dropping = 1'b0;
      end
    end else if (fill == 0) begin
      await_result(STATUS_EMPTY, '0, 1'b0, 1'b1, '0);
    end else begin
      count = (in_read_count > MAX_COUNT) ? MAX_COUNT : in_read_count;
      len = length_mem[head_slot];
      if (len > RECORD_BYTES) len = RECORD_BYTES;
      n = (count < len) ? count : len;
      if (n == 0) begin
        await_result(STATUS_OK, '0, 1'b0, 1'b1, '0);
      end else begin
        for (int unsigned k = 0; k < n; k++) begin
          await_result(STATUS_OK, byte_mem[head_slot*RECORD_BYTES + k], 1'b1, k + 1 == n,
                       n[LEN_W-1:0]);
        end
      end
      head_slot = ring_next(head_slot);
      fill--;
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst_n) begin
      head_slot    = 0;
      tail_slot    = 0;
      fill         = 0;
      open_len     = 0;
      dropping     = 1'b0;
      record_limit = LIMIT_RESET;
      awaited_results.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          $error("Result with status %0d arrived while none was awaited.", out_status);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("byte", want.data, out_byte);
          check_field("valid", want.valid, out_valid);
          check_field("last", want.last, out_last);
          check_field("stored_length", want.length, out_stored_length);
        end
      end
      if (cfg_valid && cfg_ready) record_limit = cfg_data;
      if (start && !busy) predict_fifo_results();
    end
    pending_results = awaited_results.size();
  end

endmodule

// ----- dv/length_prefixed_record_fifo_unit_tb.sv -----
// Testbench top for the record FIFO: clock, reset, request and limit stimulus, and verdict.
module length_prefixed_record_fifo_unit_tb;
  import lprf_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_operation;
  logic [BYTE_W-1:0]   in_data_byte;
  logic                in_byte_valid;
  logic                in_last;
  logic [LEN_W-1:0]    in_read_count;
  logic                out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_valid;
  logic                out_last;
  logic [LEN_W-1:0]    out_stored_length;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_data;
  int                  mismatches;
  int                  pending_results;
  bit                  steady;

  length_prefixed_record_fifo_unit uut (.*);

  lprf_record_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("length_prefixed_record_fifo_unit: mismatch");
    $finish;
  end

  task automatic pause(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start        <= 1'b0;
      in_data_byte <= BYTE_W'($urandom);
    end
  endtask

  task automatic random_gap();
    int r;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 25) pause($urandom_range(1, 3));
      else if (r < 29) pause($urandom_range(8, 30));
    end
  endtask

  task automatic send(op_t op, logic [BYTE_W-1:0] data, logic bv, logic last,
                      logic [LEN_W-1:0] count);
    random_gap();
    @(negedge clk);
    in_operation  <= op;
    in_data_byte  <= data;
    in_byte_valid <= bv;
    in_last       <= last;
    in_read_count <= count;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_read(logic [LEN_W-1:0] count);
    send(OP_READ, BYTE_W'($urandom), 1'($urandom), 1'($urandom), count);
  endtask

  task automatic send_record(int len, bit noisy);
    if (len == 0) begin
      send(OP_WRITE, BYTE_W'($urandom), 1'b0, 1'b1, LEN_W'($urandom));
    end else begin
      for (int i = 0; i < len; i++) begin
        if (noisy && $urandom_range(0, 29) == 0) send_read(LEN_W'($urandom_range(0, 127)));
        send(OP_WRITE, BYTE_W'($urandom), !noisy || $urandom_range(0, 9) != 0, i == len - 1,
             LEN_W'($urandom));
      end
    end
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
      start <= 1'b0;
    end while (pending_results != 0);
    pause(4);
  endtask

  task automatic write_limit(logic [LEN_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int budget);
    int sent;
    int len;
    int read_pct;
    sent = 0;
    read_pct = $urandom_range(15, 60);
    while (sent < budget) begin
      if ($urandom_range(0, 99) < read_pct) begin
        send_read(LEN_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 12)
                                                      : $urandom_range(0, 127)));
        sent++;
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
        send_record(len, 1'b1);
        sent += (len == 0) ? 1 : len;
      end
    end
  endtask

  initial begin
    logic [LEN_W-1:0] limits [6];
    limits = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd33};
    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = OP_WRITE;
    in_data_byte  = '0;
    in_byte_valid = 1'b0;
    in_last       = 1'b0;
    in_read_count = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    steady        = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_read(7'd10);
    send(OP_WRITE, 8'h00, 1'b0, 1'b1, '0);
    send_read(7'd5);
    send(OP_WRITE, 8'hFF, 1'b1, 1'b0, '0);
    send(OP_WRITE, 8'h00, 1'b1, 1'b0, '0);
    send(OP_WRITE, 8'hA5, 1'b1, 1'b1, '0);
    send_read(7'd0);
    send(OP_WRITE, 8'h00, 1'b1, 1'b0, 7'd127);
    send(OP_WRITE, 8'hFF, 1'b1, 1'b1, 7'd127);
    send_read(7'd127);
    send(OP_WRITE, 8'h5A, 1'b1, 1'b0, '0);
    send(OP_WRITE, 8'h00, 1'b0, 1'b1, '0);
    send_read(7'd1);
    send_record(3, 1'b0);
    send_read(7'd2);
    send_read(7'd64);

    write_limit(7'd64);
    steady = 1'b1;
    repeat (16) send_record(1, 1'b0);
    send(OP_WRITE, 8'h00, 1'b0, 1'b1, '0);
    send(OP_WRITE, 8'h3C, 1'b1, 1'b0, '0);
    send_read(7'd64);
    send(OP_WRITE, 8'hC3, 1'b1, 1'b1, '0);
    send_record(1, 1'b0);
    repeat (17) send_read(7'd64);
    steady = 1'b0;
    send_record(70, 1'b0);
    send_read(7'd64);
    send_record(64, 1'b0);
    send_read(7'd127);

    foreach (limits[i]) begin
      write_limit(limits[i]);
      steady = (i % 2 == 1);
      random_phase(10);
      send_record(1, 1'b0);
    end
    steady = 1'b0;

    pause(1);
    for (int i = 0; i < 2000 && pending_results != 0; i++) @(negedge clk);
    pause(20);
    if (mismatches == 0 && pending_results == 0) begin
      $display("length_prefixed_record_fifo_unit: match");
    end else begin
      $display("length_prefixed_record_fifo_unit: mismatch");
    end
    $finish;
  end

endmodule
